>>> hw/rtl/fixed_point_alu_macros.svh
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Shared concurrent assertion wrappers for the ALU modules.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define FPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked at every clock edge, reset included.
`define FPA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FPA_ASSERT(label, clk, rst_n, prop, msg)
`define FPA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes, widths and the word passed from front to back end.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned FracBits  = 8;
  localparam int unsigned DataW     = 32;
  localparam int unsigned NumW      = DataW + FracBits;
  localparam int unsigned DivLat    = NumW;
  localparam int unsigned DivCntW   = $clog2(DivLat + 1);

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT  = 4'd4, OP_LT  = 4'd5, OP_GE  = 4'd6, OP_LE  = 4'd7,
    OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_TO_INT = 4'd14, OP_FROM_INT = 4'd15
  } op_e;

  // Class of unit that carries out a word.
  typedef enum logic [1:0] {
    CL_SIMPLE = 2'd0,
    CL_MUL    = 2'd1,
    CL_DIV    = 2'd2
  } class_e;

  // Word in the queue between front and back end.
  typedef struct packed {
    class_e            cls;
    logic [DataW-1:0]  a;
    logic [DataW-1:0]  b;
    logic [DataW-1:0]  simple_res;
    logic              cmp;
    logic              dz;
  } work_t;

  // Result word.
  typedef struct packed {
    logic [DataW-1:0] res;
    logic             cmp;
    logic             dz;
  } res_t;

endpackage

>>> hw/rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Decodes the operation and computes every operation but multiply and divide.
// ----------------------------------------------------------------------------
module fpa_front (
  input  logic [3:0]                cmd_i,
  input  logic [fpa_pkg::DataW-1:0] operand_a_i,
  input  logic [fpa_pkg::DataW-1:0] operand_b_i,
  output fpa_pkg::work_t            work_o
);

  logic sa_gt_b;
  logic sa_eq_b;

  assign sa_gt_b = $signed(operand_a_i) > $signed(operand_b_i);
  assign sa_eq_b = operand_a_i == operand_b_i;

  // Classify and evaluate the simple operations.
  always_comb begin
    work_o.a          = operand_a_i;
    work_o.b          = operand_b_i;
    work_o.cls        = fpa_pkg::CL_SIMPLE;
    work_o.simple_res = '0;
    work_o.cmp        = 1'b0;
    work_o.dz         = 1'b0;
    unique case (fpa_pkg::op_e'(cmd_i))
      fpa_pkg::OP_ADD: work_o.simple_res = operand_a_i + operand_b_i;
      fpa_pkg::OP_SUB: work_o.simple_res = operand_a_i - operand_b_i;
      fpa_pkg::OP_MUL: work_o.cls = fpa_pkg::CL_MUL;
      fpa_pkg::OP_DIV: begin
        if (operand_b_i == '0) begin
          work_o.dz = 1'b1;
        end else begin
          work_o.cls = fpa_pkg::CL_DIV;
        end
      end
      fpa_pkg::OP_GT:  work_o.cmp = sa_gt_b;
      fpa_pkg::OP_LT:  work_o.cmp = !sa_gt_b && !sa_eq_b;
      fpa_pkg::OP_GE:  work_o.cmp = sa_gt_b || sa_eq_b;
      fpa_pkg::OP_LE:  work_o.cmp = !sa_gt_b;
      fpa_pkg::OP_EQ:  work_o.cmp = sa_eq_b;
      fpa_pkg::OP_NE:  work_o.cmp = !sa_eq_b;
      fpa_pkg::OP_MIN: work_o.simple_res = sa_gt_b ? operand_b_i : operand_a_i;
      fpa_pkg::OP_MAX: work_o.simple_res = sa_gt_b ? operand_a_i : operand_b_i;
      fpa_pkg::OP_INC: work_o.simple_res = operand_a_i + fpa_pkg::DataW'(1);
      fpa_pkg::OP_DEC: work_o.simple_res = operand_a_i - fpa_pkg::DataW'(1);
      fpa_pkg::OP_TO_INT:
        work_o.simple_res = fpa_pkg::DataW'($signed(operand_a_i) >>> fpa_pkg::FracBits);
      default: work_o.simple_res = operand_a_i << fpa_pkg::FracBits;
    endcase
  end

endmodule

>>> hw/rtl/fpa_queue.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU decoupling queue
// Two-entry queue of decoded words between the front and back end.
// ----------------------------------------------------------------------------
module fpa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fpa_pkg::work_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output fpa_pkg::work_t data_o,
  output logic           empty_o
);

  fpa_pkg::work_t mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Pointer and count update.
  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU back end
// Pipelined multiplier and divider with an output queue and credit stall.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_macros.svh"
module fpa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fpa_pkg::work_t work_i,
  input  logic           valid_i,
  output logic           take_o,
  output fpa_pkg::res_t  res_o,
  output logic           empty_o,
  input  logic           pop_i
);

  localparam int unsigned Depth  = fpa_pkg::DivLat + 3;
  localparam int unsigned OutCnt = $clog2(Depth + 1);
  localparam int unsigned PtrW   = $clog2(Depth);
  localparam int unsigned NW     = fpa_pkg::NumW;
  localparam int unsigned DW     = fpa_pkg::DataW;

  // One pipeline slot per stage; each carries a partial divide.
  typedef struct packed {
    logic               vld;
    fpa_pkg::class_e    cls;
    logic [DW-1:0]      simple_res;
    logic               cmp;
    logic               dz;
    logic [NW-1:0]      num;
    logic [DW:0]        rem;
    logic [DW-1:0]      den;
    logic               neg;
    logic [2*DW-1:0]    prod;
  } stage_t;

  stage_t stg_q [fpa_pkg::DivLat+1];
  stage_t stg_d [fpa_pkg::DivLat+1];

  fpa_pkg::res_t    oq_mem_q [Depth];
  fpa_pkg::res_t    oq_rd_data_q;
  logic [PtrW-1:0]  oq_wr_q, oq_rd_q, oq_rd_d;
  logic [OutCnt-1:0] oq_cnt_q;
  logic [OutCnt-1:0] inflight_q;
  logic             oq_push, oq_pop;
  fpa_pkg::res_t    fin;
  logic [NW-1:0]    amag;
  logic [DW-1:0]    bmag;
  logic [DW-1:0]    qres;
  logic [2*DW-1:0]  shifted;

  // Credit: results in flight plus waiting never exceed the output queue.
  assign take_o  = valid_i && (OutCnt'(oq_cnt_q + inflight_q) < OutCnt'(Depth));
  assign oq_push = stg_q[fpa_pkg::DivLat].vld;
  assign oq_pop  = pop_i && !empty_o;
  assign empty_o = oq_cnt_q == '0;
  assign res_o   = oq_rd_data_q;

  assign amag = work_i.a[DW-1] ? NW'(-$signed(work_i.a)) << fpa_pkg::FracBits
                               : NW'(work_i.a) << fpa_pkg::FracBits;
  assign bmag = work_i.b[DW-1] ? DW'(-work_i.b) : work_i.b;

  // Entry stage and one restoring divide step per stage.
  always_comb begin
    stg_d[0].vld        = take_o;
    stg_d[0].cls        = work_i.cls;
    stg_d[0].simple_res = work_i.simple_res;
    stg_d[0].cmp        = work_i.cmp;
    stg_d[0].dz         = work_i.dz;
    stg_d[0].num        = amag;
    stg_d[0].rem        = '0;
    stg_d[0].den        = bmag;
    stg_d[0].neg        = work_i.a[DW-1] ^ work_i.b[DW-1];
    stg_d[0].prod       = (2*DW)'($signed(work_i.a) * $signed(work_i.b));
    for (int i = 1; i <= fpa_pkg::DivLat; i++) begin
      logic [DW:0] trial;
      stg_d[i] = stg_q[i-1];
      trial = {stg_q[i-1].rem[DW-1:0], stg_q[i-1].num[NW-1]};
      stg_d[i].num = {stg_q[i-1].num[NW-2:0], 1'b0};
      if (trial >= {1'b0, stg_q[i-1].den}) begin
        stg_d[i].rem    = trial - {1'b0, stg_q[i-1].den};
        stg_d[i].num[0] = 1'b1;
      end else begin
        stg_d[i].rem = trial;
      end
    end
  end

  // Pipeline stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= fpa_pkg::DivLat; i++) begin
        stg_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i <= fpa_pkg::DivLat; i++) begin
        stg_q[i] <= stg_d[i];
      end
    end
  end

  // Final selection of the result word.
  assign qres    = stg_q[fpa_pkg::DivLat].num[DW-1:0];
  assign shifted = (2*DW)'($signed(stg_q[fpa_pkg::DivLat].prod) >>> fpa_pkg::FracBits);
  always_comb begin
    fin.cmp = stg_q[fpa_pkg::DivLat].cmp;
    fin.dz  = stg_q[fpa_pkg::DivLat].dz;
    case (stg_q[fpa_pkg::DivLat].cls)
      fpa_pkg::CL_MUL: fin.res = shifted[DW-1:0];
      fpa_pkg::CL_DIV: fin.res = stg_q[fpa_pkg::DivLat].neg ? DW'(-qres) : qres;
      default:         fin.res = stg_q[fpa_pkg::DivLat].simple_res;
    endcase
  end

  // Read pointer after this cycle's pop.
  assign oq_rd_d = !oq_pop ? oq_rd_q :
                   (oq_rd_q == PtrW'(Depth-1)) ? '0 : oq_rd_q + PtrW'(1);

  // Output queue and in-flight count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q    <= '0;
      oq_rd_q    <= '0;
      oq_cnt_q   <= '0;
      inflight_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= (oq_wr_q == PtrW'(Depth-1)) ? '0 : oq_wr_q + PtrW'(1);
      end
      oq_rd_q    <= oq_rd_d;
      oq_cnt_q   <= oq_cnt_q + OutCnt'(oq_push) - OutCnt'(oq_pop);
      inflight_q <= inflight_q + OutCnt'(take_o) - OutCnt'(oq_push);
    end
  end

  // Result storage with a registered read of the next head; a word written
  // to the head slot in the same cycle is passed straight through.
  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_mem_q[oq_wr_q] <= fin;
    end
    if (oq_push && (oq_wr_q == oq_rd_d)) begin
      oq_rd_data_q <= fin;
    end else begin
      oq_rd_data_q <= oq_mem_q[oq_rd_d];
    end
  end

  `FPA_ASSERT(a_credit_bound, clk_i, rst_ni, (oq_cnt_q + inflight_q) <= OutCnt'(Depth), "output credit exceeded")
  `FPA_ASSERT(a_no_push_full, clk_i, rst_ni, oq_push |-> (oq_cnt_q < OutCnt'(Depth)) || oq_pop, "output queue overflow")
  `FPA_ASSERT(a_cmp_dz_excl, clk_i, rst_ni, oq_push |-> !(fin.cmp && fin.dz), "compare and divide flags both set")

endmodule

>>> hw/rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU top level
// Signed Q24.8 ALU with queue-style input and result ports.
// ----------------------------------------------------------------------------
// One word is accepted per cycle while the input queue is not full. Each word passes
// through the entry register, the 40-stage pipelined restoring divider (one quotient
// bit per stage) and the output register. A 2-entry queue separates the decoding
// front end from the execution back end, and a 43-entry result queue holds finished
// words while pop is low.
module fixed_point_alu (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [3:0]                cmd_i,
  input  logic [fpa_pkg::DataW-1:0] operand_a_i,
  input  logic [fpa_pkg::DataW-1:0] operand_b_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [fpa_pkg::DataW-1:0] result_o,
  output logic                      compare_true_o,
  output logic                      divide_by_zero_o
);

  fpa_pkg::work_t dec, qout;
  fpa_pkg::res_t  res;
  logic           q_empty, take;

  fpa_front u_front (
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .work_o      (dec)
  );

  fpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (dec),
    .full_o  (full),
    .pop_i   (take),
    .data_o  (qout),
    .empty_o (q_empty)
  );

  fpa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .work_i  (qout),
    .valid_i (!q_empty),
    .take_o  (take),
    .res_o   (res),
    .empty_o (empty),
    .pop_i   (pop)
  );

  assign result_o         = res.res;
  assign compare_true_o   = res.cmp;
  assign divide_by_zero_o = res.dz;

endmodule

>>> tb/fpa_checker.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU checker
// Watches the input and result queues, predicts each result word and
// compares it field by field with what the ALU returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic                      full_i,
  input  logic [3:0]                cmd_i,
  input  logic [fpa_pkg::DataW-1:0] operand_a_i,
  input  logic [fpa_pkg::DataW-1:0] operand_b_i,
  input  logic                      empty_i,
  input  logic                      pop_i,
  input  logic [fpa_pkg::DataW-1:0] result_i,
  input  logic                      compare_true_i,
  input  logic                      divide_by_zero_i,
  output int                        errors_o,
  output int                        pending_o,
  output int                        results_seen_o
);

  typedef struct packed {
    logic [fpa_pkg::DataW-1:0] res;
    logic                      cmp;
    logic                      dz;
  } alu_word_t;

  alu_word_t expected_q[$];
  int err_cnt = 0;
  int seen_cnt = 0;

  // Computes the result word of one ALU operation.
  function automatic alu_word_t alu_predict(fpa_pkg::op_e op, logic signed [31:0] a,
                                            logic signed [31:0] b);
    alu_word_t w;
    logic signed [63:0] prod;
    logic signed [63:0] num;
    logic [63:0] nmag;
    logic [63:0] dmag;
    logic [63:0] q;
    w = '0;
    case (op)
      fpa_pkg::OP_ADD: w.res = a + b;
      fpa_pkg::OP_SUB: w.res = a - b;
      fpa_pkg::OP_MUL: begin
        prod = 64'(a) * 64'(b);
        w.res = 32'(prod >>> fpa_pkg::FracBits);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          w.dz = 1'b1;
        end else begin
          num = 64'(a) <<< fpa_pkg::FracBits;
          nmag = num[63] ? -num : num;
          dmag = b[31] ? -64'(b) : 64'(b);
          q = nmag / dmag;
          if (num[63] != b[31]) q = -q;
          w.res = q[31:0];
        end
      end
      fpa_pkg::OP_GT: w.cmp = a > b;
      fpa_pkg::OP_LT: w.cmp = a < b;
      fpa_pkg::OP_GE: w.cmp = a >= b;
      fpa_pkg::OP_LE: w.cmp = a <= b;
      fpa_pkg::OP_EQ: w.cmp = a == b;
      fpa_pkg::OP_NE: w.cmp = a != b;
      fpa_pkg::OP_MIN: w.res = (a > b) ? b : a;
      fpa_pkg::OP_MAX: w.res = (a > b) ? a : b;
      fpa_pkg::OP_INC: w.res = a + 1;
      fpa_pkg::OP_DEC: w.res = a - 1;
      fpa_pkg::OP_TO_INT: w.res = a >>> fpa_pkg::FracBits;
      default: w.res = a << fpa_pkg::FracBits;
    endcase
    return w;
  endfunction

  assign pending_o      = expected_q.size();
  assign errors_o       = err_cnt;
  assign results_seen_o = seen_cnt;

  // Record expectations on accepted input words, compare accepted results.
  always @(posedge clk_i) begin
    alu_word_t exp_w;
    if (rst_ni) begin
      if (push_i && !full_i)
        expected_q.push_back(alu_predict(fpa_pkg::op_e'(cmd_i), operand_a_i, operand_b_i));
      if (pop_i && !empty_i) begin
        seen_cnt <= seen_cnt + 1;
        if (expected_q.size() == 0) begin
          err_cnt <= err_cnt + 1;
          $display("%0t: result word with nothing expected: res=%h", $time, result_i);
        end else begin
          exp_w = expected_q.pop_front();
          if (exp_w.res !== result_i || exp_w.cmp !== compare_true_i ||
              exp_w.dz !== divide_by_zero_i) begin
            err_cnt <= err_cnt + 1;
            $display("%0t: mismatch expected res=%h cmp=%b dz=%b actual res=%h cmp=%b dz=%b",
                     $time, exp_w.res, exp_w.cmp, exp_w.dz, result_i,
                     compare_true_i, divide_by_zero_i);
          end
        end
      end
    end
  end
endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives directed and random operations through the ALU with idle and
// stall phases and a long receiver hold-off; the checker judges results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [3:0] cmd_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic full, empty;
  logic [31:0] result_o;
  logic compare_true_o, divide_by_zero_o;
  int errors, pending, results_seen;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;
  int words_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fixed_point_alu dut (
    .clk_i, .rst_ni, .push, .full, .cmd_i, .operand_a_i, .operand_b_i,
    .empty, .pop, .result_o, .compare_true_o, .divide_by_zero_o
  );

  fpa_checker u_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .cmd_i, .operand_a_i,
    .operand_b_i, .empty_i(empty), .pop_i(pop), .result_i(result_o),
    .compare_true_i(compare_true_o), .divide_by_zero_i(divide_by_zero_o),
    .errors_o(errors), .pending_o(pending), .results_seen_o(results_seen)
  );

  // Receiver: pop at random unless held off.
  always @(posedge clk_i) begin
    pop <= rst_ni && !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one word and holds it until accepted, idling at random before it.
  // Push stays high after acceptance so that the next word can follow at once.
  task automatic send_word(fpa_pkg::op_e op, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    cmd_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    words_sent++;
  endtask

  // Random operand with a bias toward edge values.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return $urandom_range(1023) - 512;
      4: return {$urandom_range(1) ? 24'hffffff : 24'h0, 8'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Random phase under the current idle and stall rates.
  task automatic random_phase(int count);
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      a = pick_operand();
      send_word(fpa_pkg::op_e'(4'($urandom_range(15))), a,
                ($urandom_range(9) == 0) ? a : pick_operand());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes, every operation, divide by zero and overflow.
    send_word(fpa_pkg::OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
    send_word(fpa_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001);
    send_word(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_word(fpa_pkg::OP_MUL, 32'hffff_ff00, 32'h0000_0180);
    send_word(fpa_pkg::OP_DIV, 32'h0000_0300, 32'h0000_0000);
    send_word(fpa_pkg::OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
    send_word(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_word(fpa_pkg::OP_DIV, 32'hffff_fd00, 32'h0000_0200);
    send_word(fpa_pkg::OP_GT, 32'h8000_0000, 32'h7fff_ffff);
    send_word(fpa_pkg::OP_LT, 32'h8000_0000, 32'h7fff_ffff);
    send_word(fpa_pkg::OP_GE, 32'h1234_5678, 32'h1234_5678);
    send_word(fpa_pkg::OP_LE, 32'h0000_0001, 32'hffff_ffff);
    send_word(fpa_pkg::OP_EQ, 32'hffff_ffff, 32'hffff_ffff);
    send_word(fpa_pkg::OP_NE, 32'h0000_0000, 32'h0000_0000);
    send_word(fpa_pkg::OP_MIN, 32'h0000_0500, 32'h0000_0500);
    send_word(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
    send_word(fpa_pkg::OP_INC, 32'h7fff_ffff, 32'hffff_ffff);
    send_word(fpa_pkg::OP_DEC, 32'h8000_0000, 32'h0000_0000);
    send_word(fpa_pkg::OP_TO_INT, 32'hffff_ff01, 32'h0);
    send_word(fpa_pkg::OP_TO_INT, 32'h8000_0000, 32'h0);
    send_word(fpa_pkg::OP_FROM_INT, 32'hffff_ffff, 32'h0);
    send_word(fpa_pkg::OP_FROM_INT, 32'h00ff_ffff, 32'h0);

    // Long receiver hold-off while the sender keeps offering words.
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        random_phase(80);
        push <= 1'b0;
        @(posedge clk_i);
      end
    join

    random_phase(160);
    send_idle_pct = 64;
    random_phase(135);
    send_idle_pct = 0;
    recv_stall_pct = 64;
    random_phase(135);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    random_phase(135);
    recv_stall_pct = 0;
    push <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d words over all 16 operations, %0d results checked,", words_sent,
             results_seen);
    $display("with idle, stall and hold-off phases.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_front.sv
hw/rtl/fpa_queue.sv
hw/rtl/fpa_back.sv
hw/rtl/fixed_point_alu.sv
tb/fpa_checker.sv
tb/tb_top.sv
